// ===== design/mba_pkg.sv =====
// Shared types and constants of the memo block allocator.
package mba_pkg;

    localparam int FREE_SLOTS = 64;
    localparam int IDX_W      = $clog2(FREE_SLOTS);
    localparam int USED_W     = $clog2(FREE_SLOTS + 1);
    localparam int BLK_W      = 24;
    localparam int LEN_W      = 16;
    localparam int CNT_W      = 8;

    // Block count is (length + 513) / 512.
    localparam int BLOCK_ROUND = 513;
    localparam int BLOCK_SHIFT = 9;

    typedef struct packed {
        logic [BLK_W-1:0] start;
        logic [BLK_W-1:0] len;
    } extent_t;

    typedef struct packed {
        logic [LEN_W-1:0] memo_length;
        logic [BLK_W-1:0] old_start;
        logic [CNT_W-1:0] old_count;
    } request_t;

    typedef struct packed {
        logic [BLK_W-1:0] start_block;
        logic [CNT_W-1:0] block_count;
        logic [BLK_W-1:0] end_block;
        logic             extended;
        logic             truncated;
        logic             status;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_REL_BEGIN,
        ST_REL_RD,
        ST_REL_CK,
        ST_REL_DECIDE,
        ST_INS_RD,
        ST_INS_WR,
        ST_REL_CHECK,
        ST_ERA_RD,
        ST_ERA_WR,
        ST_REL_END,
        ST_FIT_BEGIN,
        ST_FIT_RD,
        ST_FIT_CK,
        ST_FIT_END,
        ST_FINAL,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RET_CHECK,
        RET_REL_END,
        RET_FINAL
    } era_ret_t;

endpackage

// ===== design/mba_if.sv =====
// Request and response channel interfaces of the memo block allocator.
interface mba_req_if;
    logic                       valid;
    logic                       ready;
    logic [mba_pkg::LEN_W-1:0]  memo_length;
    logic [mba_pkg::BLK_W-1:0]  old_start;
    logic [mba_pkg::CNT_W-1:0]  old_count;

    modport source (output valid, memo_length, old_start, old_count, input ready);
    modport sink (input valid, memo_length, old_start, old_count, output ready);
endinterface

interface mba_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [mba_pkg::BLK_W-1:0]  start_block;
    logic [mba_pkg::CNT_W-1:0]  block_count;
    logic [mba_pkg::BLK_W-1:0]  end_block;
    logic                       extended;
    logic                       truncated;
    logic                       status;

    modport source (output valid, start_block, block_count, end_block, extended, truncated,
                    status, input ready);
    modport sink (input valid, start_block, block_count, end_block, extended, truncated,
                  status, output ready);
endinterface

// ===== design/mba_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module mba_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== design/mba_ctrl.sv =====
// Sequencer that walks the free-extent memory for release, insert, erase and best fit.
module mba_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  mba_pkg::request_t          req,
    input  logic                       cfg_we,
    input  logic [mba_pkg::BLK_W-1:0]  cfg_wdata,
    output logic                       idle,
    output logic                       res_valid,
    input  logic                       res_ready,
    output mba_pkg::result_t           res
);

    mba_pkg::state_t   state_reg, state_next;
    mba_pkg::era_ret_t ret_reg, ret_next;

    logic [mba_pkg::USED_W-1:0] used_reg, used_next;
    logic [mba_pkg::USED_W-1:0] i_reg, i_next;
    logic [mba_pkg::USED_W-1:0] j_reg, j_next;
    logic [mba_pkg::USED_W-1:0] best_reg, best_next;
    logic [mba_pkg::BLK_W-1:0]  end_reg, end_next;
    logic [mba_pkg::BLK_W-1:0]  s_reg, s_next;
    logic [mba_pkg::BLK_W-1:0]  c_reg, c_next;
    logic [mba_pkg::BLK_W-1:0]  start_reg, start_next;
    logic [mba_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    mba_pkg::extent_t prev_reg, prev_next;
    mba_pkg::extent_t cur_reg, cur_next;
    mba_pkg::extent_t tv_reg, tv_next;
    mba_pkg::extent_t bval_reg, bval_next;
    logic have_prev_reg, have_prev_next;
    logic have_cur_reg, have_cur_next;
    logic place_reg, place_next;
    logic found_reg, found_next;
    logic ext_reg, ext_next;
    logic trunc_reg, trunc_next;
    logic over_reg, over_next;

    logic                       mem_we;
    logic [mba_pkg::IDX_W-1:0]  mem_waddr;
    logic [mba_pkg::IDX_W-1:0]  mem_raddr;
    mba_pkg::extent_t           mem_wdata;
    mba_pkg::extent_t           rd;

    mba_ram #(
        .DEPTH (mba_pkg::FREE_SLOTS),
        .WIDTH ($bits(mba_pkg::extent_t))
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd)
    );

    // Request decode.
    logic [mba_pkg::LEN_W:0]    len_sum;
    logic [mba_pkg::CNT_W-1:0]  req_cnt;
    logic [mba_pkg::CNT_W-1:0]  req_keep;
    logic                       req_empty;
    logic                       req_no_old;

    assign len_sum    = {1'b0, req.memo_length} + (mba_pkg::LEN_W+1)'(mba_pkg::BLOCK_ROUND);
    assign req_cnt    = len_sum[mba_pkg::BLOCK_SHIFT +: mba_pkg::CNT_W];
    assign req_keep   = (req_cnt < req.old_count) ? req_cnt : '0;
    assign req_empty  = (req.memo_length == '0);
    assign req_no_old = (req.old_start == '0);

    // Release decisions.
    logic [mba_pkg::BLK_W-1:0] stop;
    logic [mba_pkg::BLK_W-1:0] tv_end;
    logic [mba_pkg::BLK_W-1:0] cnt_w;
    logic [mba_pkg::BLK_W-1:0] place_start;
    logic merge_prev, merge_next, rel_tail, list_full;
    logic rd_before, fit_exact, fit_better;
    logic [mba_pkg::USED_W-1:0] j_inc;

    assign stop       = s_reg + c_reg;
    assign tv_end     = tv_reg.start + tv_reg.len;
    assign merge_prev = have_prev_reg && ((prev_reg.start + prev_reg.len) == s_reg);
    assign merge_next = have_cur_reg && (stop == cur_reg.start);
    assign rel_tail   = (stop == end_reg);
    assign list_full  = (used_reg == mba_pkg::USED_W'(mba_pkg::FREE_SLOTS));
    assign rd_before  = (rd.start < s_reg);
    assign cnt_w      = {{(mba_pkg::BLK_W-mba_pkg::CNT_W){1'b0}}, cnt_reg};
    assign fit_exact  = (rd.len == cnt_w);
    assign fit_better = (rd.len >= cnt_w) && (!found_reg || (rd.len < bval_reg.len));
    assign j_inc      = j_reg + 1'b1;
    assign place_start = (start_reg == '0) ? end_reg : start_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mba_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (req_empty)
                    begin
                        state_next = req_no_old ? mba_pkg::ST_DONE : mba_pkg::ST_REL_BEGIN;
                    end
                    else if (req_no_old)
                    begin
                        state_next = mba_pkg::ST_FIT_BEGIN;
                    end
                    else if (req_cnt != req.old_count)
                    begin
                        state_next = mba_pkg::ST_REL_BEGIN;
                    end
                    else
                    begin
                        state_next = mba_pkg::ST_DONE;
                    end
                end
            end
            mba_pkg::ST_REL_BEGIN:
                state_next = (c_reg == '0) ? mba_pkg::ST_REL_END : mba_pkg::ST_REL_RD;
            mba_pkg::ST_REL_RD:
                state_next = (i_reg == used_reg) ? mba_pkg::ST_REL_DECIDE : mba_pkg::ST_REL_CK;
            mba_pkg::ST_REL_CK:
                state_next = rd_before ? mba_pkg::ST_REL_RD : mba_pkg::ST_REL_DECIDE;
            mba_pkg::ST_REL_DECIDE:
            begin
                if (merge_prev)
                begin
                    state_next = merge_next ? mba_pkg::ST_ERA_RD : mba_pkg::ST_REL_CHECK;
                end
                else if (merge_next)
                begin
                    state_next = mba_pkg::ST_REL_CHECK;
                end
                else if (rel_tail || list_full)
                begin
                    state_next = mba_pkg::ST_REL_END;
                end
                else
                begin
                    state_next = mba_pkg::ST_INS_RD;
                end
            end
            mba_pkg::ST_INS_RD:
                state_next = (j_reg == i_reg) ? mba_pkg::ST_REL_CHECK : mba_pkg::ST_INS_WR;
            mba_pkg::ST_INS_WR:
                state_next = mba_pkg::ST_INS_RD;
            mba_pkg::ST_REL_CHECK:
                state_next = (tv_end == end_reg) ? mba_pkg::ST_ERA_RD : mba_pkg::ST_REL_END;
            mba_pkg::ST_ERA_RD:
            begin
                if (j_inc >= used_reg)
                begin
                    unique case (ret_reg)
                        mba_pkg::RET_CHECK:   state_next = mba_pkg::ST_REL_CHECK;
                        mba_pkg::RET_REL_END: state_next = mba_pkg::ST_REL_END;
                        mba_pkg::RET_FINAL:   state_next = mba_pkg::ST_FINAL;
                        default:              state_next = mba_pkg::ST_FINAL;
                    endcase
                end
                else
                begin
                    state_next = mba_pkg::ST_ERA_WR;
                end
            end
            mba_pkg::ST_ERA_WR:
                state_next = mba_pkg::ST_ERA_RD;
            mba_pkg::ST_REL_END:
                state_next = place_reg ? mba_pkg::ST_FIT_BEGIN : mba_pkg::ST_DONE;
            mba_pkg::ST_FIT_BEGIN:
                state_next = ((start_reg == '0) && (used_reg != '0)) ? mba_pkg::ST_FIT_RD
                                                                     : mba_pkg::ST_FINAL;
            mba_pkg::ST_FIT_RD:
                state_next = (i_reg == used_reg) ? mba_pkg::ST_FIT_END : mba_pkg::ST_FIT_CK;
            mba_pkg::ST_FIT_CK:
                state_next = fit_exact ? mba_pkg::ST_FIT_END : mba_pkg::ST_FIT_RD;
            mba_pkg::ST_FIT_END:
                state_next = (found_reg && (bval_reg.len == cnt_w)) ? mba_pkg::ST_ERA_RD
                                                                     : mba_pkg::ST_FINAL;
            mba_pkg::ST_FINAL:
                state_next = mba_pkg::ST_DONE;
            mba_pkg::ST_DONE:
                state_next = res_ready ? mba_pkg::ST_IDLE : mba_pkg::ST_DONE;
            default:
                state_next = mba_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ret_next       = ret_reg;
        used_next      = used_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        best_next      = best_reg;
        end_next       = end_reg;
        s_next         = s_reg;
        c_next         = c_reg;
        start_next     = start_reg;
        cnt_next       = cnt_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        tv_next        = tv_reg;
        bval_next      = bval_reg;
        have_prev_next = have_prev_reg;
        have_cur_next  = have_cur_reg;
        place_next     = place_reg;
        found_next     = found_reg;
        ext_next       = ext_reg;
        trunc_next     = trunc_reg;
        over_next      = over_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = tv_reg;
        mem_raddr      = '0;

        unique case (state_reg)
            mba_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ext_next   = 1'b0;
                    trunc_next = 1'b0;
                    over_next  = 1'b0;
                    if (req_empty)
                    begin
                        cnt_next   = '0;
                        start_next = '0;
                        s_next     = req.old_start;
                        c_next     = {{(mba_pkg::BLK_W-mba_pkg::CNT_W){1'b0}}, req.old_count};
                        place_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next   = req_cnt;
                        s_next     = req.old_start
                                   + {{(mba_pkg::BLK_W-mba_pkg::CNT_W){1'b0}}, req_keep};
                        c_next     = {{(mba_pkg::BLK_W-mba_pkg::CNT_W){1'b0}},
                                      req.old_count - req_keep};
                        place_next = 1'b1;
                        start_next = (req_keep == '0) ? '0 : req.old_start;
                        // Same count at a real extent keeps the memo where it is.
                        if (!req_no_old && (req_cnt == req.old_count))
                        begin
                            start_next = req.old_start;
                        end
                    end
                end
            end
            mba_pkg::ST_REL_BEGIN:
            begin
                i_next         = '0;
                have_prev_next = 1'b0;
                have_cur_next  = 1'b0;
            end
            mba_pkg::ST_REL_RD:
                mem_raddr = i_reg[mba_pkg::IDX_W-1:0];
            mba_pkg::ST_REL_CK:
            begin
                if (rd_before)
                begin
                    prev_next      = rd;
                    have_prev_next = 1'b1;
                    i_next         = i_reg + 1'b1;
                end
                else
                begin
                    cur_next      = rd;
                    have_cur_next = 1'b1;
                end
            end
            mba_pkg::ST_REL_DECIDE:
            begin
                if (merge_prev)
                begin
                    tv_next.start = prev_reg.start;
                    tv_next.len   = prev_reg.len + c_reg
                                  + (merge_next ? cur_reg.len : '0);
                    mem_we        = 1'b1;
                    mem_waddr     = mba_pkg::IDX_W'(i_reg - 1'b1);
                    mem_wdata     = tv_next;
                    best_next     = i_reg - 1'b1;
                    j_next        = i_reg;
                    ret_next      = mba_pkg::RET_CHECK;
                end
                else if (merge_next)
                begin
                    tv_next.start = s_reg;
                    tv_next.len   = cur_reg.len + c_reg;
                    mem_we        = 1'b1;
                    mem_waddr     = i_reg[mba_pkg::IDX_W-1:0];
                    mem_wdata     = tv_next;
                    best_next     = i_reg;
                end
                else if (rel_tail)
                begin
                    end_next   = s_reg;
                    trunc_next = 1'b1;
                end
                else if (list_full)
                begin
                    over_next = 1'b1;
                end
                else
                begin
                    tv_next.start = s_reg;
                    tv_next.len   = c_reg;
                    best_next     = i_reg;
                    j_next        = used_reg;
                end
            end
            mba_pkg::ST_INS_RD:
            begin
                if (j_reg == i_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = i_reg[mba_pkg::IDX_W-1:0];
                    used_next = used_reg + 1'b1;
                end
                else
                begin
                    mem_raddr = mba_pkg::IDX_W'(j_reg - 1'b1);
                end
            end
            mba_pkg::ST_INS_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[mba_pkg::IDX_W-1:0];
                mem_wdata = rd;
                j_next    = j_reg - 1'b1;
            end
            mba_pkg::ST_REL_CHECK:
            begin
                // The merged or new extent reaches the end of file: give it back.
                if (tv_end == end_reg)
                begin
                    end_next   = tv_reg.start;
                    trunc_next = 1'b1;
                    j_next     = best_reg;
                    ret_next   = mba_pkg::RET_REL_END;
                end
            end
            mba_pkg::ST_ERA_RD:
            begin
                if (j_inc >= used_reg)
                begin
                    used_next = used_reg - 1'b1;
                end
                else
                begin
                    mem_raddr = j_inc[mba_pkg::IDX_W-1:0];
                end
            end
            mba_pkg::ST_ERA_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[mba_pkg::IDX_W-1:0];
                mem_wdata = rd;
                j_next    = j_inc;
            end
            mba_pkg::ST_FIT_BEGIN:
            begin
                i_next     = '0;
                found_next = 1'b0;
            end
            mba_pkg::ST_FIT_RD:
                mem_raddr = i_reg[mba_pkg::IDX_W-1:0];
            mba_pkg::ST_FIT_CK:
            begin
                // An exact size match ends the scan; otherwise keep the tightest fit.
                if (fit_exact || fit_better)
                begin
                    best_next  = i_reg;
                    bval_next  = rd;
                    found_next = 1'b1;
                end
                i_next     = i_reg + 1'b1;
            end
            mba_pkg::ST_FIT_END:
            begin
                if (found_reg)
                begin
                    start_next = bval_reg.start;
                    if (bval_reg.len == cnt_w)
                    begin
                        j_next   = best_reg;
                        ret_next = mba_pkg::RET_FINAL;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = best_reg[mba_pkg::IDX_W-1:0];
                        mem_wdata.start = bval_reg.start + cnt_w;
                        mem_wdata.len   = bval_reg.len - cnt_w;
                    end
                end
            end
            mba_pkg::ST_FINAL:
            begin
                start_next = place_start;
                if (place_start == end_reg)
                begin
                    ext_next = 1'b1;
                    end_next = end_reg + cnt_w;
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_we)
        begin
            end_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mba_pkg::ST_IDLE;
            used_reg  <= '0;
            end_reg   <= mba_pkg::BLK_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            end_reg   <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg       <= ret_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        best_reg      <= best_next;
        s_reg         <= s_next;
        c_reg         <= c_next;
        start_reg     <= start_next;
        cnt_reg       <= cnt_next;
        prev_reg      <= prev_next;
        cur_reg       <= cur_next;
        tv_reg        <= tv_next;
        bval_reg      <= bval_next;
        have_prev_reg <= have_prev_next;
        have_cur_reg  <= have_cur_next;
        place_reg     <= place_next;
        found_reg     <= found_next;
        ext_reg       <= ext_next;
        trunc_reg     <= trunc_next;
        over_reg      <= over_next;
    end

    assign idle      = (state_reg == mba_pkg::ST_IDLE);
    assign res_valid = (state_reg == mba_pkg::ST_DONE);

    always_comb
    begin
        res.start_block = start_reg;
        res.block_count = cnt_reg;
        res.end_block   = end_reg;
        res.extended    = ext_reg;
        res.truncated   = trunc_reg;
        res.status      = over_reg;
    end

`ifndef SYNTH
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= mba_pkg::USED_W'(mba_pkg::FREE_SLOTS))
        else $error("free list count beyond capacity");

    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ({1'b0, mem_waddr} <= used_reg))
        else $error("free list write beyond the live entries");

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && idle) |=> !idle)
        else $error("accepted request did not start the sequencer");

    a_over_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mba_pkg::ST_REL_DECIDE && over_next && !over_reg) |-> list_full)
        else $error("overflow flagged with room in the list");
`endif

endmodule

// ===== design/memo_block_allocator.sv =====
// Memo block allocator: best-fit free-extent allocator with a 64-entry free list in RAM.
// One request is in work at a time; the sequencer's single RAM read port sets the rate.
// The output register lets a new request enter while the last response waits.
// Reset empties the free list and sets the end pointer to 1; the RAM itself is not cleared.
module memo_block_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    mba_req_if.sink                    req,
    mba_rsp_if.source                  rsp,
    input  logic                       cfg_we,
    input  logic [mba_pkg::BLK_W-1:0]  cfg_wdata
);

    mba_pkg::request_t req_data;
    mba_pkg::result_t  res;
    mba_pkg::result_t  rsp_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              idle, res_valid, res_ready, req_fire;

    assign req_data.memo_length = req.memo_length;
    assign req_data.old_start   = req.old_start;
    assign req_data.old_count   = req.old_count;

    assign req.ready = idle;
    assign req_fire  = req.valid && idle;
    assign res_ready = !rsp_valid_reg || rsp.ready;

    mba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req_fire),
        .req       (req_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .idle      (idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.start_block = rsp_reg.start_block;
    assign rsp.block_count = rsp_reg.block_count;
    assign rsp.end_block   = rsp_reg.end_block;
    assign rsp.extended    = rsp_reg.extended;
    assign rsp.truncated   = rsp_reg.truncated;
    assign rsp.status      = rsp_reg.status;

endmodule
